@@ sv/tjc_pkg.sv @@
package tjc_pkg;

   localparam int unsigned POS_W   = 24;
   localparam int unsigned SPEED_W = 16;
   localparam int unsigned ACCEL_W = 5;
   // jog_speed * accel_tenths never exceeds 65535 * 30, which fits in 21 bits
   localparam int unsigned PROD_W  = 21;
   // floor(65535 * 30 / 12) fits in 18 bits
   localparam int unsigned STEP_W  = 18;
   // Wide enough for a position plus or minus any 24-bit signed step
   localparam int unsigned SUM_W   = POS_W + 2;

   // Division by three of a value below 2**19: multiply by ceil(2**20 / 3), drop 20 bits
   localparam int unsigned DIV3_SHIFT = 20;
   localparam int unsigned DIV3_IN_W  = PROD_W - 2;
   localparam logic [DIV3_IN_W-1:0] DIV3_MUL = 19'd349526;

   localparam logic [ACCEL_W-1:0] ACCEL_START = 5'd10;
   localparam logic [ACCEL_W-1:0] ACCEL_TOP   = 5'd30;

   localparam logic signed [SUM_W-1:0] POS_MAX_WIDE = 26'sd8388607;
   localparam logic signed [SUM_W-1:0] POS_MIN_WIDE = -26'sd8388608;
   localparam logic signed [POS_W-1:0] POS_MAX      = 24'sd8388607;
   localparam logic signed [POS_W-1:0] POS_MIN      = -24'sd8388608;

   // Command codes
   localparam logic [3:0] FUNC_SETPOS  = 4'd0;
   localparam logic [3:0] FUNC_SETTGT  = 4'd1;
   localparam logic [3:0] FUNC_JOG     = 4'd2;
   localparam logic [3:0] FUNC_START   = 4'd3;
   localparam logic [3:0] FUNC_STOP    = 4'd4;
   localparam logic [3:0] FUNC_TICK    = 4'd5;
   localparam logic [3:0] FUNC_MOVE    = 4'd6;
   localparam logic [3:0] FUNC_ESTOP   = 4'd7;
   localparam logic [3:0] FUNC_RESET   = 4'd8;
   localparam logic [3:0] FUNC_READ    = 4'd9;

   // Result status codes
   localparam logic [1:0] STATUS_DONE   = 2'd0;
   localparam logic [1:0] STATUS_ESTOP  = 2'd1;
   localparam logic [1:0] STATUS_LIMIT  = 2'd2;
   localparam logic [1:0] STATUS_NOACT  = 2'd3;

   localparam logic [1:0] AXIS_NONE = 2'd3;

   // Configuration register indexes
   localparam logic [2:0] CSR_MIN_X     = 3'd0;
   localparam logic [2:0] CSR_MAX_X     = 3'd1;
   localparam logic [2:0] CSR_MIN_Y     = 3'd2;
   localparam logic [2:0] CSR_MAX_Y     = 3'd3;
   localparam logic [2:0] CSR_MIN_Z     = 3'd4;
   localparam logic [2:0] CSR_MAX_Z     = 3'd5;
   localparam logic [2:0] CSR_LIMIT_EN  = 3'd6;
   localparam logic [2:0] CSR_JOG_SPEED = 3'd7;

   localparam logic signed [POS_W-1:0] LIMIT_MIN_RESET = -24'sd50000;
   localparam logic signed [POS_W-1:0] LIMIT_MAX_RESET = 24'sd50000;
   localparam logic [2:0]              LIMIT_EN_RESET  = 3'd7;
   localparam logic [SPEED_W-1:0]      JOG_SPEED_RESET = 16'd1000;
   localparam logic [PROD_W-1:0]       PROD_RESET      = 21'd10000;

   typedef struct packed {
      logic [3:0]              func;
      logic [1:0]              axis;
      logic                    positive;
      logic signed [POS_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [1:0]              result_axis;
      logic signed [POS_W-1:0] position;
      logic signed [POS_W-1:0] target;
      logic signed [POS_W-1:0] attempted_position;
      logic                    jogging;
      logic                    estop_active;
   } rsp_type;

   // Changes to the acceleration factor asked for by one command
   typedef struct packed {
      logic restart;
      logic speed_up;
   } rate_ctrl_type;

   // State changes asked for by one command
   typedef struct packed {
      logic                    pos_we;
      logic                    tgt_we;
      logic [1:0]              axis;
      logic signed [POS_W-1:0] pos_val;
      logic signed [POS_W-1:0] tgt_val;
      logic                    jog_active;
      logic [1:0]              jog_axis;
      logic                    jog_direction;
      logic                    estop;
   } state_upd_type;

endpackage

@@ sv/three_axis_jog_controller_top.sv @@
// Three-axis jog controller. Keeps a current and a target position in micrometres for
// the X, Y and Z axes, a continuous-jog latch and an emergency-stop latch, and executes
// one command per request: set position, set target, single jog, start or stop jog,
// timer tick, move-to, emergency stop, emergency reset or read. Every request yields
// exactly one response carrying a status and the position, target and checked position
// of the axis concerned. A request sits in an input register while the single-pass
// command logic works on it, and the response and the new state are registered
// together when the request moves on, so a request passes through the input register
// and then the response register, and the block takes one request every cycle while
// the response output is not stalled. When the response output is stalled the input
// register holds its request and req_stall rises only once that register is full. The
// soft limits, the per-axis limit enable and the jog speed are to be written through
// the csr_ port only while no request is in flight; the block itself does not enforce
// this. A jog speed write takes effect on the very next tick.
module three_axis_jog_controller_top
   import tjc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [POS_W-1:0]  csr_data
);

   // Input register
   req_type                 req_ff;
   logic                    in_vld_ff, in_vld_in;
   logic                    advance;

   // Response register
   rsp_type                 rsp_ff;
   logic                    out_vld_ff, out_vld_in;

   // Configuration
   logic signed [POS_W-1:0] min_lim_ff [3];
   logic signed [POS_W-1:0] max_lim_ff [3];
   logic [2:0]              limit_en_ff;

   // Axis and latch state
   logic signed [POS_W-1:0] pos_ff [3];
   logic signed [POS_W-1:0] tgt_ff [3];
   logic                    jog_active_ff;
   logic [1:0]              jog_axis_ff;
   logic                    jog_dir_ff;
   logic                    estop_ff;

   // Command logic results
   state_upd_type           upd;
   rate_ctrl_type           rate_ctrl;
   rate_ctrl_type           rate_ctrl_gated;
   rsp_type                 rsp_in;
   logic [ACCEL_W-1:0]      accel_tenths;
   logic [STEP_W-1:0]       step;
   logic                    speed_we;

   // The held request moves on whenever the response register is empty or is
   // being emptied this cycle.
   assign advance    = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall  = in_vld_ff && !advance;
   assign in_vld_in  = (req_valid && !req_stall) || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Configuration writes
   assign speed_we = csr_we && (csr_index == CSR_JOG_SPEED);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            min_lim_ff[i] <= LIMIT_MIN_RESET;
            max_lim_ff[i] <= LIMIT_MAX_RESET;
         end
         limit_en_ff <= LIMIT_EN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_X:     min_lim_ff[0] <= csr_data;
            CSR_MAX_X:     max_lim_ff[0] <= csr_data;
            CSR_MIN_Y:     min_lim_ff[1] <= csr_data;
            CSR_MAX_Y:     max_lim_ff[1] <= csr_data;
            CSR_MIN_Z:     min_lim_ff[2] <= csr_data;
            CSR_MAX_Z:     max_lim_ff[2] <= csr_data;
            CSR_LIMIT_EN:  limit_en_ff   <= csr_data[2:0];
            CSR_JOG_SPEED: begin
               // held in the jog rate unit
            end
            default: begin
            end
         endcase
      end
   end

   // State is committed at the same edge as the response it belongs to.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            tgt_ff[i] <= '0;
         end
         jog_active_ff <= 1'b0;
         jog_axis_ff   <= 2'd0;
         jog_dir_ff    <= 1'b0;
         estop_ff      <= 1'b0;
      end else if (advance) begin
         if (upd.pos_we) begin
            pos_ff[upd.axis] <= upd.pos_val;
         end
         if (upd.tgt_we) begin
            tgt_ff[upd.axis] <= upd.tgt_val;
         end
         jog_active_ff <= upd.jog_active;
         jog_axis_ff   <= upd.jog_axis;
         jog_dir_ff    <= upd.jog_direction;
         estop_ff      <= upd.estop;
      end
   end

   assign rate_ctrl_gated.restart  = advance && rate_ctrl.restart;
   assign rate_ctrl_gated.speed_up = advance && rate_ctrl.speed_up;

   tjc_jog_rate u_jog_rate (
      .clock        (clock),
      .reset        (reset),
      .speed_we     (speed_we),
      .speed_data   (csr_data[SPEED_W-1:0]),
      .ctrl         (rate_ctrl_gated),
      .accel_tenths (accel_tenths),
      .step         (step)
   );

   tjc_step u_step (
      .req           (req_ff),
      .pos           (pos_ff),
      .tgt           (tgt_ff),
      .min_lim       (min_lim_ff),
      .max_lim       (max_lim_ff),
      .limit_enable  (limit_en_ff),
      .jog_active    (jog_active_ff),
      .jog_axis      (jog_axis_ff),
      .jog_direction (jog_dir_ff),
      .estop         (estop_ff),
      .step          (step),
      .upd           (upd),
      .rate_ctrl     (rate_ctrl),
      .rsp           (rsp_in)
   );

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // The acceleration factor never leaves its ramp.
   a_accel_range: assert property (@(posedge clock) disable iff (reset)
      (accel_tenths >= ACCEL_START) && (accel_tenths <= ACCEL_TOP))
      else $error("acceleration factor out of range");

   // An emergency stop always ends a continuous jog, and no jog starts while latched.
   a_no_jog_in_estop: assert property (@(posedge clock) disable iff (reset)
      !(jog_active_ff && estop_ff))
      else $error("jog active while emergency stop latched");

   // The jog axis is only ever loaded from a valid axis.
   a_jog_axis_valid: assert property (@(posedge clock) disable iff (reset)
      jog_axis_ff != AXIS_NONE)
      else $error("jog axis invalid");

   // A request refused by the emergency stop reports the latch as set.
   a_estop_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_ESTOP)) |-> rsp_data.estop_active)
      else $error("emergency stop status without latch");
`endif

endmodule

@@ sv/tjc_jog_rate.sv @@
module tjc_jog_rate
   import tjc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 speed_we,
   input  logic [SPEED_W-1:0]   speed_data,
   input  rate_ctrl_type        ctrl,
   output logic [ACCEL_W-1:0]   accel_tenths,
   output logic [STEP_W-1:0]    step
);

   // product_ff always holds jog_speed * accel_tenths, so the step only needs a
   // divide by twelve: two bits of shift, then a reciprocal multiply by three.
   logic [SPEED_W-1:0]           speed_ff;
   logic [ACCEL_W-1:0]           accel_ff, accel_in;
   logic [PROD_W-1:0]            product_ff, product_in;
   logic [PROD_W-1:0]            speed_wide;
   logic [PROD_W-1:0]            start_product;
   logic [DIV3_IN_W-1:0]         quarter;
   logic [2*DIV3_IN_W-1:0]       div_prod;

   assign speed_wide    = {{(PROD_W-SPEED_W){1'b0}}, speed_ff};
   assign start_product = (speed_wide << 3) + (speed_wide << 1);

   always_comb begin
      accel_in   = accel_ff;
      product_in = product_ff;
      if (speed_we) begin
         product_in = PROD_W'({{(PROD_W-SPEED_W){1'b0}}, speed_data} *
                              {{(PROD_W-ACCEL_W){1'b0}}, accel_ff});
      end else if (ctrl.restart) begin
         accel_in   = ACCEL_START;
         product_in = start_product;
      end else if (ctrl.speed_up && (accel_ff < ACCEL_TOP)) begin
         accel_in   = accel_ff + 5'd1;
         product_in = product_ff + speed_wide;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff   <= JOG_SPEED_RESET;
         accel_ff   <= ACCEL_START;
         product_ff <= PROD_RESET;
      end else begin
         if (speed_we) begin
            speed_ff <= speed_data;
         end
         accel_ff   <= accel_in;
         product_ff <= product_in;
      end
   end

   assign quarter      = product_ff[PROD_W-1:2];
   assign div_prod     = quarter * DIV3_MUL;
   assign step         = div_prod[DIV3_SHIFT+STEP_W-1:DIV3_SHIFT];
   assign accel_tenths = accel_ff;

endmodule

@@ sv/tjc_step.sv @@
module tjc_step
   import tjc_pkg::*;
(
   input  req_type                 req,
   input  logic signed [POS_W-1:0] pos [3],
   input  logic signed [POS_W-1:0] tgt [3],
   input  logic signed [POS_W-1:0] min_lim [3],
   input  logic signed [POS_W-1:0] max_lim [3],
   input  logic [2:0]              limit_enable,
   input  logic                    jog_active,
   input  logic [1:0]              jog_axis,
   input  logic                    jog_direction,
   input  logic                    estop,
   input  logic [STEP_W-1:0]       step,
   output state_upd_type           upd,
   output rate_ctrl_type           rate_ctrl,
   output rsp_type                 rsp
);

   logic [1:0]              a;
   logic                    valid;
   logic                    addresses;
   logic signed [POS_W-1:0] pos_sel, tgt_sel, min_sel, max_sel;
   logic                    le_sel;
   logic signed [SUM_W-1:0] value_wide, delta, sum;
   logic signed [POS_W-1:0] sat_pos, attempted;
   logic                    in_limits;
   logic                    checked;
   logic [1:0]              status;

   assign a         = (req.func == FUNC_TICK) ? jog_axis : req.axis;
   assign valid     = (a != AXIS_NONE);
   assign addresses = (req.func <= FUNC_START) || (req.func == FUNC_MOVE) ||
                      (req.func == FUNC_READ);

   always_comb begin
      pos_sel = '0;
      tgt_sel = '0;
      min_sel = '0;
      max_sel = '0;
      le_sel  = 1'b0;
      case (a)
         2'd0: begin
            pos_sel = pos[0]; tgt_sel = tgt[0];
            min_sel = min_lim[0]; max_sel = max_lim[0]; le_sel = limit_enable[0];
         end
         2'd1: begin
            pos_sel = pos[1]; tgt_sel = tgt[1];
            min_sel = min_lim[1]; max_sel = max_lim[1]; le_sel = limit_enable[1];
         end
         2'd2: begin
            pos_sel = pos[2]; tgt_sel = tgt[2];
            min_sel = min_lim[2]; max_sel = max_lim[2]; le_sel = limit_enable[2];
         end
         default: begin
         end
      endcase
   end

   // One adder serves both the single jog and the timed jog step
   assign value_wide = SUM_W'(req.value);
   always_comb begin
      if (req.func == FUNC_TICK) begin
         delta = jog_direction ? $signed({8'd0, step}) : -$signed({8'd0, step});
      end else begin
         delta = req.positive ? value_wide : -value_wide;
      end
   end

   assign sum = SUM_W'(pos_sel) + delta;

   always_comb begin
      if (sum > POS_MAX_WIDE) begin
         sat_pos = POS_MAX;
      end else if (sum < POS_MIN_WIDE) begin
         sat_pos = POS_MIN;
      end else begin
         sat_pos = sum[POS_W-1:0];
      end
   end

   assign attempted = (req.func == FUNC_MOVE) ? req.value : sat_pos;
   assign in_limits = !le_sel || ((attempted >= min_sel) && (attempted <= max_sel));

   always_comb begin
      upd.pos_we        = 1'b0;
      upd.tgt_we        = 1'b0;
      upd.axis          = a;
      upd.pos_val       = req.value;
      upd.tgt_val       = req.value;
      upd.jog_active    = jog_active;
      upd.jog_axis      = jog_axis;
      upd.jog_direction = jog_direction;
      upd.estop         = estop;
      rate_ctrl         = '0;
      checked           = 1'b0;
      status            = STATUS_DONE;

      if (addresses && !valid) begin
         status = STATUS_NOACT;
      end else begin
         case (req.func)
            FUNC_SETPOS: begin
               upd.pos_we = 1'b1;
            end
            FUNC_SETTGT: begin
               upd.tgt_we = 1'b1;
            end
            FUNC_JOG: begin
               if (estop) begin
                  status = STATUS_ESTOP;
               end else begin
                  checked     = 1'b1;
                  upd.pos_val = attempted;
                  if (in_limits) begin
                     upd.pos_we = 1'b1;
                  end else begin
                     status = STATUS_LIMIT;
                  end
               end
            end
            FUNC_START: begin
               if (estop) begin
                  status = STATUS_ESTOP;
               end else begin
                  upd.jog_axis      = a;
                  upd.jog_direction = req.positive;
                  upd.jog_active    = 1'b1;
                  rate_ctrl.restart = 1'b1;
               end
            end
            FUNC_STOP: begin
               upd.jog_active    = 1'b0;
               rate_ctrl.restart = 1'b1;
            end
            FUNC_TICK: begin
               if (!jog_active || estop || !valid) begin
                  status = STATUS_NOACT;
               end else begin
                  checked     = 1'b1;
                  upd.pos_val = attempted;
                  if (in_limits) begin
                     upd.pos_we         = 1'b1;
                     rate_ctrl.speed_up = 1'b1;
                  end else begin
                     upd.jog_active    = 1'b0;
                     rate_ctrl.restart = 1'b1;
                     status            = STATUS_LIMIT;
                  end
               end
            end
            FUNC_MOVE: begin
               if (estop) begin
                  status = STATUS_ESTOP;
               end else begin
                  checked = 1'b1;
                  if (in_limits) begin
                     upd.pos_we = 1'b1;
                     upd.tgt_we = 1'b1;
                  end else begin
                     status = STATUS_LIMIT;
                  end
               end
            end
            FUNC_ESTOP: begin
               if (estop) begin
                  status = STATUS_NOACT;
               end else begin
                  upd.estop         = 1'b1;
                  upd.jog_active    = 1'b0;
                  rate_ctrl.restart = 1'b1;
               end
            end
            FUNC_RESET: begin
               if (estop) begin
                  upd.estop = 1'b0;
               end else begin
                  status = STATUS_NOACT;
               end
            end
            FUNC_READ: begin
            end
            default: begin
               status = STATUS_NOACT;
            end
         endcase
      end
   end

   always_comb begin
      rsp.status       = status;
      rsp.jogging      = upd.jog_active;
      rsp.estop_active = upd.estop;
      if (valid) begin
         rsp.result_axis        = a;
         rsp.position           = upd.pos_we ? upd.pos_val : pos_sel;
         rsp.target             = upd.tgt_we ? upd.tgt_val : tgt_sel;
         rsp.attempted_position = checked ? attempted : rsp.position;
      end else begin
         rsp.result_axis        = AXIS_NONE;
         rsp.position           = '0;
         rsp.target             = '0;
         rsp.attempted_position = '0;
      end
   end

endmodule
